@@ hw/rtl/mlst_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlst_pkg: shared types and constants of the sorted multi-list key table
// Field widths, request and status codes, the controller states and the
// command that the controller hands to each list row and its cells.
// ----------------------------------------------------------------------------
package mlst_pkg;

	localparam int NUM_LISTS_DEF  = 4;
	localparam int LIST_DEPTH_DEF = 16;

	localparam int KEY_W       = 32;
	localparam int REQ_W       = 2;
	localparam int LIDX_W      = 2;
	localparam int POS_W       = 4;
	localparam int STAT_W      = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int REMOVED_W   = 7;

	localparam int COUNT_OUT_MAX = 31;
	localparam int REMOVED_MAX   = 127;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BEYOND    = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WORK,
		S_HOLD
	} state_t;

	// Command to a row of cells: insert the search key, or take one step of
	// removal of the search key.
	typedef struct packed {
		logic ins;
		logic rem;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [KEY_W-1:0] key;
		logic [COUNT_OUT_W-1:0]  count;
		logic [REMOVED_W-1:0]    removed;
	} res_t;

endpackage

`default_nettype wire

@@ hw/rtl/mlst_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlst_cell: one entry of a sorted list
// Holds one key, compares it with the search key and takes its next value
// from itself, the search key or one of its two neighbours.
// ----------------------------------------------------------------------------
module mlst_cell import mlst_pkg::*; (
	input  wire                     clk,
	input  cmd_t                    cmd,
	input  wire signed [KEY_W-1:0]  key,
	input  wire                     occ,
	input  wire                     is_tail,
	input  wire signed [KEY_W-1:0]  left_key,
	input  wire                     left_gt,
	input  wire signed [KEY_W-1:0]  right_key,
	output logic signed [KEY_W-1:0] val,
	output logic                    gt,
	output logic                    eq
);

	logic signed [KEY_W-1:0] val_q;
	logic                    ge;

	assign val = val_q;
	assign gt  = occ && (val_q > key);
	assign ge  = occ && (val_q >= key);
	assign eq  = occ && (val_q == key);

	// On insert, entries greater than the key move one place up and the key
	// lands in the first such place, or at the tail. On removal, the run of
	// equal keys and everything above it moves one place down.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_gt) begin
				val_q <= left_key;
			end else if (gt || is_tail) begin
				val_q <= key;
			end
		end else if (cmd.rem && ge) begin
			val_q <= right_key;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mlst_row.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlst_row: one sorted list as a row of cells
// Keeps the list's entry count, wires the cells to their neighbours and
// gathers the match flag and the entry at the requested position.
// ----------------------------------------------------------------------------
module mlst_row import mlst_pkg::*; #(
	parameter  int LIST_DEPTH = LIST_DEPTH_DEF,
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  cmd_t                    cmd,
	input  wire signed [KEY_W-1:0]  key,
	input  wire [POS_W-1:0]         position,
	output logic [CNT_W-1:0]        count,
	output logic                    has_match,
	output logic signed [KEY_W-1:0] rd_key
);

	logic [CNT_W-1:0]        count_q;
	logic signed [KEY_W-1:0] val_w [LIST_DEPTH];
	logic [LIST_DEPTH-1:0]   gt_w;
	logic [LIST_DEPTH-1:0]   eq_w;
	cmd_t                    cell_cmd;

	assign count     = count_q;
	assign has_match = |eq_w;

	always_comb begin
		cell_cmd.ins = cmd.ins;
		cell_cmd.rem = cmd.rem && has_match;
	end

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic signed [KEY_W-1:0] left_key;
		logic                    left_gt;
		logic signed [KEY_W-1:0] right_key;

		if (i == 0) begin : g_first
			assign left_key = val_w[i];
			assign left_gt  = 1'b0;
		end else begin : g_inner
			assign left_key = val_w[i-1];
			assign left_gt  = gt_w[i-1];
		end

		if (i == LIST_DEPTH - 1) begin : g_last
			assign right_key = val_w[i];
		end else begin : g_body
			assign right_key = val_w[i+1];
		end

		mlst_cell u_cell (
			.clk       (clk),
			.cmd       (cell_cmd),
			.key       (key),
			.occ       (CNT_W'(i) < count_q),
			.is_tail   (count_q == CNT_W'(i)),
			.left_key  (left_key),
			.left_gt   (left_gt),
			.right_key (right_key),
			.val       (val_w[i]),
			.gt        (gt_w[i]),
			.eq        (eq_w[i])
		);
	end

	always_comb begin
		rd_key = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (int'(position) == i) begin
				rd_key = rd_key | val_w[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.rem && has_match) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/multi_list_sorted_key_table_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_list_sorted_key_table_unit: several sorted lists of signed keys
// Each list is a row of cells that compare with the key in parallel and
// shift their entries to insert or remove it; reads pick one cell out.
// ----------------------------------------------------------------------------
//   Channel | Handshake           | Carries
//   input   | in_valid / in_ready | req_type, list_index, key, position
//   output  | out_valid/out_ready | status, key_out, count_out, removed_count
//
// An item is taken in the idle state and worked on alone. Insert, read and
// an unused code pass from the work state straight into the output register,
// and the next item is accepted back in the idle state. A remove stays in work
// while any list still holds an equal key, since every row drops one matching
// entry per cycle.
// Reset clears all list counts; the cells themselves are not cleared.
// A result that is not taken waits in a holding register until the output
// register is free; no further item is accepted until then.
// ----------------------------------------------------------------------------
module multi_list_sorted_key_table_unit import mlst_pkg::*; #(
	parameter int NUM_LISTS  = NUM_LISTS_DEF,
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire [REQ_W-1:0]         req_type,
	input  wire [LIDX_W-1:0]        list_index,
	input  wire signed [KEY_W-1:0]  key,
	input  wire [POS_W-1:0]         position,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [STAT_W-1:0]       status,
	output logic signed [KEY_W-1:0] key_out,
	output logic [COUNT_OUT_W-1:0]  count_out,
	output logic [REMOVED_W-1:0]    removed_count
);

	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int CX_W   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
	localparam int RM_RAW = $clog2(NUM_LISTS * LIST_DEPTH + 1);
	localparam int RM_W   = (RM_RAW > REMOVED_W) ? RM_RAW : REMOVED_W;
	localparam int NM_W   = $clog2(NUM_LISTS + 1);

	state_t                  state_q, state_d;
	logic [REQ_W-1:0]        req_q;
	logic [LIDX_W-1:0]       lst_q;
	logic signed [KEY_W-1:0] key_q;
	logic [POS_W-1:0]        pos_q;
	logic [RM_W-1:0]         rm_q;
	logic                    out_valid_q;
	res_t                    out_q;
	res_t                    hold_q;

	cmd_t                    row_cmd   [NUM_LISTS];
	logic [CNT_W-1:0]        row_cnt   [NUM_LISTS];
	logic [NUM_LISTS-1:0]    row_match;
	logic signed [KEY_W-1:0] row_key   [NUM_LISTS];

	logic [CNT_W-1:0]        cnt_sel;
	logic signed [KEY_W-1:0] key_sel;
	logic                    lst_ok;
	logic                    any_match;
	logic [NM_W-1:0]         n_match;
	logic                    full;
	logic                    pos_ok;
	logic [CX_W-1:0]         res_cnt_x;
	res_t                    res;
	res_t                    out_d;

	logic                    take_in;
	logic                    out_free;
	logic                    ins_go;
	logic                    rem_go;
	logic                    load_out;
	logic                    load_hold;

	always_comb begin
		for (int l = 0; l < NUM_LISTS; l++) begin
			row_cmd[l].ins = ins_go && (int'(lst_q) == l);
			row_cmd[l].rem = rem_go;
		end
	end

	for (genvar l = 0; l < NUM_LISTS; l++) begin : g_row
		mlst_row #(
			.LIST_DEPTH (LIST_DEPTH)
		) u_row (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (row_cmd[l]),
			.key       (key_q),
			.position  (pos_q),
			.count     (row_cnt[l]),
			.has_match (row_match[l]),
			.rd_key    (row_key[l])
		);
	end

	// A list index beyond the lists present selects nothing: no room and no
	// entries.
	always_comb begin
		cnt_sel = '0;
		key_sel = '0;
		lst_ok  = 1'b0;
		n_match = '0;
		for (int l = 0; l < NUM_LISTS; l++) begin
			if (int'(lst_q) == l) begin
				cnt_sel = row_cnt[l];
				key_sel = row_key[l];
				lst_ok  = 1'b1;
			end
			n_match = n_match + NM_W'(row_match[l]);
		end
		any_match = |row_match;
		full      = !lst_ok || (cnt_sel == CNT_W'(LIST_DEPTH));
		pos_ok    = lst_ok && (CX_W'(pos_q) < CX_W'(cnt_sel));
	end

	always_comb begin
		res.status = STAT_OK;
		res.key    = '0;
		res.removed = '0;
		res_cnt_x  = CX_W'(cnt_sel);
		case (req_q)
			REQ_INSERT: begin
				if (full) begin
					res.status = STAT_FULL;
				end else begin
					res_cnt_x = CX_W'(cnt_sel) + CX_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (rm_q == '0) begin
					res.status = STAT_NOT_FOUND;
				end
				res.removed = (rm_q > RM_W'(REMOVED_MAX)) ? REMOVED_W'(REMOVED_MAX)
				                                          : rm_q[REMOVED_W-1:0];
			end
			REQ_READ: begin
				if (pos_ok) begin
					res.key = key_sel;
				end else begin
					res.status = STAT_BEYOND;
				end
			end
			default: begin
			end
		endcase
		res.count = (res_cnt_x > CX_W'(COUNT_OUT_MAX)) ? COUNT_OUT_W'(COUNT_OUT_MAX)
		                                               : res_cnt_x[COUNT_OUT_W-1:0];
	end

	assign out_free = !out_valid_q || out_ready;
	assign take_in  = in_valid && in_ready;
	assign out_d    = (state_q == S_HOLD) ? hold_q : res;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ins_go    = 1'b0;
		rem_go    = 1'b0;
		load_out  = 1'b0;
		load_hold = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_WORK;
				end
			end
			S_WORK: begin
				if ((req_q == REQ_REMOVE) && any_match) begin
					rem_go = 1'b1;
				end else begin
					ins_go = (req_q == REQ_INSERT) && !full;
					if (out_free) begin
						load_out = 1'b1;
						state_d  = S_IDLE;
					end else begin
						load_hold = 1'b1;
						state_d   = S_HOLD;
					end
				end
			end
			S_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rm_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_in) begin
				rm_q <= '0;
			end else if (rem_go) begin
				rm_q <= rm_q + RM_W'(n_match);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_q <= req_type;
			lst_q <= list_index;
			key_q <= key;
			pos_q <= position;
		end
		if (load_hold) begin
			hold_q <= res;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign key_out       = out_q.key;
	assign count_out     = out_q.count;
	assign removed_count = out_q.removed;

endmodule

`default_nettype wire

@@ hw/rtl/mlst_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlst_checker: port-level checks of the sorted multi-list key table
// Watches the top level's handshakes and result fields over time.
// ----------------------------------------------------------------------------
module mlst_checker import mlst_pkg::*; (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    in_valid,
	input wire                    in_ready,
	input wire                    out_valid,
	input wire                    out_ready,
	input wire [STAT_W-1:0]       status,
	input wire signed [KEY_W-1:0] key_out,
	input wire [REMOVED_W-1:0]    removed_count
);

	// A result that is not taken stays as it is.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(key_out))
		else $error("output item changed while stalled");

	// Items are worked on one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");

	a_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> key_out == '0)
		else $error("key shown with a failing status");

	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (removed_count != '0) |-> status == STAT_OK)
		else $error("entries removed but status not ok");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_NOT_FOUND) |-> removed_count == '0)
		else $error("key not found but a removal reported");

endmodule

bind multi_list_sorted_key_table_unit mlst_checker u_mlst_checker (.*);

`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted multi-list key table
// Drives insert, remove, read and unused requests over a valid/ready input,
// predicts every result from a shadow copy of the lists, and compares each
// result taken from the output channel with the oldest prediction. Both
// channels idle in random bursts except in the closing stretch.
// ----------------------------------------------------------------------------
module testbench import mlst_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_LISTS = NUM_LISTS_DEF;
	localparam int DEPTH   = LIST_DEPTH_DEF;

	// The request code with no operation behind it.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	wire                     in_ready;
	logic [REQ_W-1:0]        req_type;
	logic [LIDX_W-1:0]       list_index;
	logic signed [KEY_W-1:0] key;
	logic [POS_W-1:0]        position;
	wire                     out_valid;
	logic                    out_ready = 1'b0;
	wire [STAT_W-1:0]        status;
	wire signed [KEY_W-1:0]  key_out;
	wire [COUNT_OUT_W-1:0]   count_out;
	wire [REMOVED_W-1:0]     removed_count;

	// Shadow copy of the lists and the results still owed by the block.
	logic signed [KEY_W-1:0] shadow_keys [N_LISTS][DEPTH];
	int unsigned             shadow_count [N_LISTS];
	res_t                    pending_results [$];

	int fail_count = 0;
	int stall_left = 0;
	bit idle_on    = 1'b1;

	multi_list_sorted_key_table_unit #(
		.NUM_LISTS  (N_LISTS),
		.LIST_DEPTH (DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.list_index    (list_index),
		.key           (key),
		.position      (position),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.key_out       (key_out),
		.count_out     (count_out),
		.removed_count (removed_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

	// Applies one request to the shadow lists and returns the result it owes.
	function automatic res_t apply_request(input logic [REQ_W-1:0] req,
			input logic [LIDX_W-1:0] lst, input logic signed [KEY_W-1:0] k,
			input logic [POS_W-1:0] pos);
		res_t        r;
		int unsigned n;
		int unsigned at;
		int unsigned w;
		int unsigned removed;
		int unsigned i;
		int unsigned l;
		r       = '0;
		removed = 0;
		case (req)
			REQ_INSERT: begin
				n = shadow_count[lst];
				if (n >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					// The new key goes after every key equal to it.
					at = 0;
					while (at < n && !(shadow_keys[lst][at] > k))
						at++;
					for (i = n; i > at; i--)
						shadow_keys[lst][i] = shadow_keys[lst][i-1];
					shadow_keys[lst][at] = k;
					shadow_count[lst]    = n + 1;
				end
			end
			REQ_REMOVE: begin
				for (l = 0; l < N_LISTS; l++) begin
					w = 0;
					for (i = 0; i < shadow_count[l]; i++) begin
						if (shadow_keys[l][i] != k) begin
							shadow_keys[l][w] = shadow_keys[l][i];
							w++;
						end else begin
							removed++;
						end
					end
					shadow_count[l] = w;
				end
				if (removed == 0)
					r.status = STAT_NOT_FOUND;
			end
			REQ_READ: begin
				if (pos < shadow_count[lst])
					r.key = shadow_keys[lst][pos];
				else
					r.status = STAT_BEYOND;
			end
			default: ;
		endcase
		r.count   = COUNT_OUT_W'(shadow_count[lst] > COUNT_OUT_MAX ?
				COUNT_OUT_MAX : shadow_count[lst]);
		r.removed = REMOVED_W'(removed > REMOVED_MAX ? REMOVED_MAX : removed);
		return r;
	endfunction

	task automatic send_item(input logic [REQ_W-1:0] req, input logic [LIDX_W-1:0] lst,
			input logic signed [KEY_W-1:0] k, input logic [POS_W-1:0] pos);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		list_index <= lst;
		key        <= k;
		position   <= pos;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(apply_request(req, lst, k, pos));
	endtask

	// Output side pacing: ready drops for random bursts while idling is enabled.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 10) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {status, key_out, count_out, removed_count};
			if (pending_results.size() == 0) begin
				if (fail_count < 10)
					$display({"result with no request waiting: ",
						"status %0d key %0d count %0d removed %0d"},
						got.status, got.key, got.count, got.removed);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.key !== want.key ||
						got.count !== want.count || got.removed !== want.removed) begin
					if (fail_count < 10)
						$display({"mismatch: expected status %0d key %0d count %0d ",
							"removed %0d, got status %0d key %0d count %0d ",
							"removed %0d"},
							want.status, want.key, want.count, want.removed,
							got.status, got.key, got.count, got.removed);
					fail_count++;
				end
			end
		end
	end

	// Fills one list to the brim with extremes and duplicates, then covers a
	// full insert, reads at both ends and beyond, a remove that finds nothing,
	// a remove that hits several lists, and the unused request code.
	task automatic test_directed_cases();
		logic signed [KEY_W-1:0] fill_keys [16] = '{
			32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1, 32'sd5, 32'sd5, 32'sd5, 32'sd1,
			-32'sd5, 32'sd100, 32'sd5, 32'sh7FFFFFFF, 32'sh80000000, 32'sd2, -32'sd2, 32'sd3
		};
		int i;
		for (i = 0; i < 16; i++)
			send_item(REQ_INSERT, 2'd3, fill_keys[i], 4'd0);
		send_item(REQ_INSERT, 2'd3, 32'sd9, 4'd0);
		send_item(REQ_READ, 2'd3, 32'sd0, 4'd15);
		send_item(REQ_READ, 2'd3, 32'sd0, 4'd0);
		send_item(REQ_INSERT, 2'd1, 32'sd5, 4'd0);
		send_item(REQ_READ, 2'd1, 32'sd0, 4'd15);
		send_item(REQ_REMOVE, 2'd0, 32'sd12345, 4'd0);
		send_item(REQ_REMOVE, 2'd3, 32'sd5, 4'd0);
		send_item(REQ_UNUSED, 2'd2, 32'sh5A5A5A5A, 4'd9);
		send_item(REQ_READ, 2'd3, 32'sd0, 4'd11);
	endtask

	// Random traffic over a small key pool, so that removes find matches and
	// lists hold runs of equal keys; phases with heavy inserts push lists full.
	task automatic test_random_mix(input int n_items);
		logic signed [KEY_W-1:0] key_pool [6];
		logic [REQ_W-1:0]        req;
		logic signed [KEY_W-1:0] k;
		int                      ins_weight;
		int                      sel;
		int                      i;
		int                      j;
		ins_weight = 45;
		for (i = 0; i < n_items; i++) begin
			if (i % 150 == 0) begin
				for (j = 0; j < 6; j++)
					key_pool[j] = $urandom();
				if ($urandom_range(0, 1) == 0) begin
					key_pool[0] = 32'sh80000000;
					key_pool[1] = 32'sh7FFFFFFF;
				end
				ins_weight = ($urandom_range(0, 2) == 0) ? 75 : 45;
			end
			sel = $urandom_range(0, 99);
			if (sel < ins_weight)
				req = REQ_INSERT;
			else if (sel < ins_weight + 12)
				req = REQ_REMOVE;
			else if (sel < 96)
				req = REQ_READ;
			else
				req = REQ_UNUSED;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, 5)];
			else
				k = $urandom();
			send_item(req, LIDX_W'($urandom_range(0, 3)), k, POS_W'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		int l;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		req_type   <= REQ_INSERT;
		list_index <= '0;
		key        <= '0;
		position   <= '0;
		for (l = 0; l < N_LISTS; l++)
			shadow_count[l] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_mix(1100);
		idle_on = 1'b0;
		test_random_mix(150);
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
